// ===== rtl/sts_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted table search package
// Shared widths, operation and status codes, and controller/datapath structs.
// ----------------------------------------------------------------------------
package sts_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;

    localparam int OP_W        = 2;
    localparam int KEY_W       = 31;
    localparam int ST_W        = 2;
    localparam int IDX_W       = 11;
    localparam int SUM_W       = 48;

    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 64;

    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd1;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic accept;
        logic rd_start;
        logic probe;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic in_query;
        logic search_done;
        logic out_free;
    } t_stat;

endpackage

// ===== rtl/sts_ctrl.sv =====
// ----------------------------------------------------------------------------
// Sorted table search controller
// Sequences accept, search probes and result write-back for one item.
// ----------------------------------------------------------------------------
module sts_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_valid,
    output logic          o_s_ready,
    input  sts_pkg::t_stat i_stat,
    output sts_pkg::t_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_START  = 2'd1;
    localparam logic [1:0] S_PROBE  = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state   = r_state;
        o_cmd     = '0;
        o_s_ready = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = i_stat.in_query ? S_START : S_FINISH;
                end
            end
            S_START: begin
                o_cmd.rd_start = 1'b1;
                n_state        = S_PROBE;
            end
            S_PROBE: begin
                o_cmd.probe = 1'b1;
                if (i_stat.search_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_s_ready && i_s_valid) |=> (r_state != S_IDLE))
        else $error("Accepted transaction did not start processing.");

    a_finish_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH && i_stat.out_free) |=> (r_state == S_IDLE))
        else $error("Result write-back did not return to idle.");

endmodule

// ===== rtl/sts_dpath.sv =====
// ----------------------------------------------------------------------------
// Sorted table search datapath
// Key memory, lower-bound search bounds, position, total and result register.
// ----------------------------------------------------------------------------
module sts_dpath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  sts_pkg::t_cmd                i_cmd,
    output sts_pkg::t_stat               o_stat,
    input  logic [sts_pkg::OP_W-1:0]     i_op,
    input  logic [sts_pkg::KEY_W-1:0]    i_key,
    input  logic                         i_m_ready,
    output logic                         o_m_valid,
    output logic [sts_pkg::ST_W-1:0]     o_status,
    output logic [sts_pkg::IDX_W-1:0]    o_index,
    output logic [sts_pkg::SUM_W-1:0]    o_total
);

    logic [sts_pkg::KEY_W-1:0]  r_mem [sts_pkg::TABLE_DEPTH];
    logic [sts_pkg::KEY_W-1:0]  r_rdata;

    logic [sts_pkg::OP_W-1:0]   r_op;
    logic [sts_pkg::KEY_W-1:0]  r_key;
    logic [sts_pkg::CNT_W-1:0]  r_lo;
    logic [sts_pkg::CNT_W-1:0]  r_hi;
    logic                       r_found;
    logic [sts_pkg::ADDR_W-1:0] r_dist;

    logic [sts_pkg::CNT_W-1:0]  r_count;
    logic [sts_pkg::ADDR_W-1:0] r_pos;
    logic [sts_pkg::SUM_W-1:0]  r_sum;

    logic                       r_out_valid;
    logic [sts_pkg::ST_W-1:0]   r_out_status;
    logic [sts_pkg::CNT_W-1:0]  r_out_index;
    logic [sts_pkg::SUM_W-1:0]  r_out_total;

    logic [sts_pkg::CNT_W-1:0]  n_lo;
    logic [sts_pkg::CNT_W-1:0]  n_hi;
    logic [sts_pkg::CNT_W-1:0]  n_count;
    logic [sts_pkg::ADDR_W-1:0] n_pos;
    logic [sts_pkg::SUM_W-1:0]  n_sum;
    logic [sts_pkg::ST_W-1:0]   n_out_status;
    logic [sts_pkg::CNT_W-1:0]  n_out_index;

    logic                       w_lo_lt_hi;
    logic [sts_pkg::CNT_W:0]    w_mid_sum;
    logic [sts_pkg::ADDR_W-1:0] w_mid;
    logic                       w_rd_en;
    logic [sts_pkg::ADDR_W-1:0] w_rd_addr;
    logic                       w_wr_en;
    logic                       w_full;
    logic [sts_pkg::SUM_W:0]    w_sum_ext;
    logic [sts_pkg::ADDR_W-1:0] w_hi_addr;

    function automatic logic [sts_pkg::ADDR_W-1:0] f_probe_addr(
        input logic [sts_pkg::CNT_W-1:0] lo,
        input logic [sts_pkg::CNT_W-1:0] hi
    );
        logic [sts_pkg::CNT_W:0] sum;
        sum = {1'b0, lo} + {1'b0, hi} - (sts_pkg::CNT_W + 1)'(1);
        if (lo < hi) begin
            f_probe_addr = sum[sts_pkg::ADDR_W:1];
        end else begin
            f_probe_addr = hi[sts_pkg::ADDR_W-1:0];
        end
    endfunction

    always_comb begin
        w_lo_lt_hi = (r_lo < r_hi);
        w_mid_sum  = {1'b0, r_lo} + {1'b0, r_hi} - (sts_pkg::CNT_W + 1)'(1);
        w_mid      = w_mid_sum[sts_pkg::ADDR_W:1];
        n_lo       = r_lo;
        n_hi       = r_hi;
        if (r_rdata < r_key) begin
            n_lo = {1'b0, w_mid} + sts_pkg::CNT_W'(1);
        end else begin
            n_hi = {1'b0, w_mid};
        end
        w_rd_en   = i_cmd.rd_start | (i_cmd.probe & w_lo_lt_hi);
        w_rd_addr = i_cmd.rd_start ? f_probe_addr(r_lo, r_hi) : f_probe_addr(n_lo, n_hi);
        w_hi_addr = r_hi[sts_pkg::ADDR_W-1:0];
    end

    always_comb begin
        w_full       = (r_count >= sts_pkg::CNT_W'(sts_pkg::TABLE_DEPTH));
        w_sum_ext    = {1'b0, r_sum} + (sts_pkg::SUM_W + 1)'(r_dist);
        w_wr_en      = 1'b0;
        n_count      = r_count;
        n_pos        = r_pos;
        n_sum        = r_sum;
        n_out_status = sts_pkg::ST_OK;
        n_out_index  = r_count;
        case (r_op)
            sts_pkg::OP_LOAD: begin
                if (w_full) begin
                    n_out_status = sts_pkg::ST_FULL;
                end else begin
                    w_wr_en     = i_cmd.finish;
                    n_count     = r_count + sts_pkg::CNT_W'(1);
                    n_out_index = n_count;
                end
            end
            sts_pkg::OP_QUERY: begin
                n_out_index = r_hi;
                if (r_found) begin
                    n_pos = w_hi_addr;
                    n_sum = w_sum_ext[sts_pkg::SUM_W] ? '1 : w_sum_ext[sts_pkg::SUM_W-1:0];
                end else begin
                    n_out_status = sts_pkg::ST_NOT_FOUND;
                end
            end
            sts_pkg::OP_CLEAR: begin
                n_count     = '0;
                n_pos       = '0;
                n_sum       = '0;
                n_out_index = '0;
            end
            default: begin
                n_out_index = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rdata <= r_mem[w_rd_addr];
        end
        if (w_wr_en) begin
            r_mem[r_count[sts_pkg::ADDR_W-1:0]] <= r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op  <= i_op;
            r_key <= i_key;
            r_lo  <= '0;
            r_hi  <= r_count;
        end
        if (i_cmd.probe && w_lo_lt_hi) begin
            r_lo <= n_lo;
            r_hi <= n_hi;
        end
        if (i_cmd.probe && !w_lo_lt_hi) begin
            r_found <= (r_hi < r_count) && (r_rdata == r_key);
            r_dist  <= (w_hi_addr > r_pos) ? (w_hi_addr - r_pos) : (r_pos - w_hi_addr);
        end
        if (i_cmd.finish) begin
            r_out_status <= n_out_status;
            r_out_index  <= n_out_index;
            r_out_total  <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_pos       <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.finish) begin
                r_count     <= n_count;
                r_pos       <= n_pos;
                r_sum       <= n_sum;
                r_out_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.in_query    = (i_op == sts_pkg::OP_QUERY);
    assign o_stat.search_done = !w_lo_lt_hi;
    assign o_stat.out_free    = !r_out_valid || i_m_ready;

    assign o_m_valid = r_out_valid;
    assign o_status  = r_out_status;
    assign o_index   = sts_pkg::IDX_W'(r_out_index);
    assign o_total   = r_out_total;

    a_search_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.probe |-> (r_lo <= r_hi))
        else $error("Search bounds crossed during a probe.");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= sts_pkg::CNT_W'(sts_pkg::TABLE_DEPTH))
        else $error("Entry count exceeds the table depth.");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos == '0) || ({1'b0, r_pos} < r_count))
        else $error("Current position lies beyond the loaded entries.");

endmodule

// ===== rtl/sorted_table_search_distance_top.sv =====
// ----------------------------------------------------------------------------
// Sorted table search distance top level
// Binary lower-bound search over a loaded key table with distance totals.
//
// Channel   Direction  tdata fields (low bit up)              tuser fields
// s_axis    in         key_value[30:0], zero pad [31]         opcode[1:0]
// m_axis    out        found_index[10:0], total_distance      status[1:0]
//                      [58:11], zero pad [63:59]
//
// A query starts with one key memory read, then makes one key memory probe
// per cycle until its search bounds meet. Loads, clears and other
// operations skip the search. Reset is synchronous and active low and empties
// the table. A finished result waits in an output register while the next
// transaction is accepted; write-back of that next result stalls until the
// register is taken.
// ----------------------------------------------------------------------------
module sorted_table_search_distance_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [sts_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // key_value[30:0]
    input  logic [sts_pkg::OP_W-1:0]        s_axis_tuser,  // opcode[1:0]
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [sts_pkg::M_TDATA_W-1:0]   m_axis_tdata,  // found_index, total_distance
    output logic [sts_pkg::ST_W-1:0]        m_axis_tuser   // status[1:0]
);

    sts_pkg::t_cmd  w_cmd;
    sts_pkg::t_stat w_stat;

    logic [sts_pkg::IDX_W-1:0] w_index;
    logic [sts_pkg::SUM_W-1:0] w_total;

    sts_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_stat    (w_stat),
        .o_cmd     (w_cmd)
    );

    sts_dpath u_dpath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .o_stat    (w_stat),
        .i_op      (s_axis_tuser),
        .i_key     (s_axis_tdata[sts_pkg::KEY_W-1:0]),
        .i_m_ready (m_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .o_status  (m_axis_tuser),
        .o_index   (w_index),
        .o_total   (w_total)
    );

    assign m_axis_tdata = sts_pkg::M_TDATA_W'({w_total, w_index});

endmodule

// ===== tb/tb_sorted_table_search_distance_top.sv =====
// ----------------------------------------------------------------------------
// Sorted table search distance testbench
// Streams load, query, clear and unused-opcode transactions into the block in
// random bursts while the result side stalls on its own pattern. Each accepted
// input is run through a local model of the key table, the search position and
// the running distance total. Each result is checked field by field against
// the oldest predicted result.
// ----------------------------------------------------------------------------
module tb_sorted_table_search_distance_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sts_pkg::*;

    localparam logic [OP_W-1:0]  OP_NOP      = 2'd3;
    localparam logic [SUM_W-1:0] SUM_MAX     = '1;
    localparam int               STIM_ITEMS  = 1380;
    localparam int               DRAIN_WAIT  = 40;
    localparam int               PRINT_LIMIT = 100;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
    } t_table_cmd;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [IDX_W-1:0] found_index;
        logic [SUM_W-1:0] total;
    } t_table_reply;

    typedef enum logic [1:0] {
        RX_STEADY,
        RX_PATTERN,
        RX_SPARSE
    } t_rx_mode;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic [OP_W-1:0]      s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [ST_W-1:0]      m_axis_tuser;

    t_table_cmd   pending_cmds[$];
    t_table_reply predicted_replies[$];
    logic [KEY_W-1:0] table_image[$];

    logic [KEY_W-1:0] model_keys [TABLE_DEPTH];
    int unsigned      model_count;
    int unsigned      model_pos;
    logic [SUM_W-1:0] model_sum;

    int           mismatch_count;
    int           burst_left;
    int           gap_left;
    t_rx_mode     rx_mode;
    int           rx_mode_left;
    logic [15:0]  rx_pattern;
    t_table_cmd   next_cmd;
    t_table_reply want;

    sorted_table_search_distance_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // key_value[30:0], zero pad [31]
        .s_axis_tuser  (s_axis_tuser),   // opcode[1:0]
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // found_index[10:0], total_distance[58:11]
        .m_axis_tuser  (m_axis_tuser)    // status[1:0]
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] exp_val);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT) begin
            $display("%0t: %s got 0x%0h, predicted 0x%0h", $realtime, what, got, exp_val);
        end
    endtask

    function automatic t_table_reply predict_table_step(input logic [OP_W-1:0] op,
                                                        input logic [KEY_W-1:0] key);
        t_table_reply reply;
        int unsigned  lo;
        int unsigned  hi;
        int unsigned  mid;
        int unsigned  step_len;
        logic [SUM_W:0] new_sum;
        reply.status      = ST_OK;
        reply.found_index = IDX_W'(model_count);
        case (op)
            OP_LOAD: begin
                if (model_count >= TABLE_DEPTH) begin
                    reply.status = ST_FULL;
                end else begin
                    model_keys[model_count] = key;
                    model_count++;
                    reply.found_index = IDX_W'(model_count);
                end
            end
            OP_QUERY: begin
                lo = 0;
                hi = model_count;
                while (lo < hi) begin
                    mid = (lo + hi - 1) / 2;
                    if (model_keys[mid] < key) begin
                        lo = mid + 1;
                    end else begin
                        hi = mid;
                    end
                end
                reply.found_index = IDX_W'(hi);
                if (hi >= model_count || model_keys[hi] != key) begin
                    reply.status = ST_NOT_FOUND;
                end else begin
                    step_len  = (hi > model_pos) ? hi - model_pos : model_pos - hi;
                    new_sum   = {1'b0, model_sum} + (SUM_W + 1)'(step_len);
                    model_sum = (new_sum > {1'b0, SUM_MAX}) ? SUM_MAX : new_sum[SUM_W-1:0];
                    model_pos = hi;
                end
            end
            OP_CLEAR: begin
                model_count       = 0;
                model_pos         = 0;
                model_sum         = '0;
                reply.found_index = '0;
            end
            default: begin
            end
        endcase
        reply.total = model_sum;
        return reply;
    endfunction

    task automatic add_cmd(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key);
        pending_cmds.push_back('{op: op, key: key});
        if (op == OP_LOAD && table_image.size() < TABLE_DEPTH) begin
            table_image.push_back(key);
        end else if (op == OP_CLEAR) begin
            table_image.delete();
        end
    endtask

    task automatic add_ascending_loads(input int count, input int unsigned max_step);
        logic [31:0] next_key;
        for (int i = 0; i < count; i++) begin
            if (table_image.size() == 0) begin
                next_key = $urandom_range(max_step, 0);
            end else begin
                next_key = table_image[$] + $urandom_range(max_step, 0);
            end
            if (next_key > 32'h7FFF_FFFF) begin
                next_key = 32'h7FFF_FFFF;
            end
            add_cmd(OP_LOAD, next_key[KEY_W-1:0]);
        end
    endtask

    task automatic add_queries(input int count);
        logic [KEY_W-1:0] probe_key;
        int               pick;
        int               entries;
        for (int i = 0; i < count; i++) begin
            pick    = $urandom_range(99, 0);
            entries = table_image.size();
            if (entries != 0 && pick < 65) begin
                probe_key = table_image[$urandom_range(entries - 1, 0)];
            end else if (entries != 0 && pick < 80) begin
                probe_key = table_image[$urandom_range(entries - 1, 0)] + 1'b1;
            end else if (entries != 0 && pick < 88) begin
                probe_key = table_image[$urandom_range(entries - 1, 0)] - 1'b1;
            end else if (pick < 94) begin
                probe_key = '1;
            end else begin
                probe_key = KEY_W'($urandom);
            end
            add_cmd(OP_QUERY, probe_key);
            if ($urandom_range(29, 0) == 0) begin
                add_cmd(OP_NOP, KEY_W'($urandom));
            end
        end
    endtask

    // Sender: transactions leave the pending queue in bursts with random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
            burst_left    <= $urandom_range(24, 1);
            gap_left      <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predicted_replies.push_back(
                    predict_table_step(s_axis_tuser, s_axis_tdata[KEY_W-1:0]));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left      <= gap_left - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_cmds.size() != 0) begin
                    next_cmd = pending_cmds.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {1'b0, next_cmd.key};
                    s_axis_tuser  <= next_cmd.op;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(24, 1);
                        case ($urandom_range(9, 0))
                            0, 1, 2: gap_left <= 0;
                            3:       gap_left <= $urandom_range(30, 10);
                            default: gap_left <= $urandom_range(6, 1);
                        endcase
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result and drives ready in steady, patterned or sparse modes.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_mode       = RX_STEADY;
            rx_mode_left  = 0;
            rx_pattern    = 16'hFFFF;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (predicted_replies.size() == 0) begin
                    report_mismatch("result transaction with none predicted",
                                    m_axis_tdata, '0);
                end else begin
                    want = predicted_replies.pop_front();
                    if (m_axis_tuser !== want.status) begin
                        report_mismatch("status", 64'(m_axis_tuser), 64'(want.status));
                    end
                    if (m_axis_tdata[10:0] !== want.found_index) begin
                        report_mismatch("found_index", 64'(m_axis_tdata[10:0]),
                                        64'(want.found_index));
                    end
                    if (m_axis_tdata[58:11] !== want.total) begin
                        report_mismatch("total_distance", 64'(m_axis_tdata[58:11]),
                                        64'(want.total));
                    end
                    if (m_axis_tdata[63:59] !== '0) begin
                        report_mismatch("tdata pad", 64'(m_axis_tdata[63:59]), '0);
                    end
                end
            end
            if (rx_mode_left == 0) begin
                rx_mode      = t_rx_mode'($urandom_range(2, 0));
                rx_mode_left = $urandom_range(120, 20);
                rx_pattern   = 16'($urandom);
            end else begin
                rx_mode_left--;
            end
            rx_pattern = {rx_pattern[14:0], rx_pattern[15]};
            case (rx_mode)
                RX_STEADY:  m_axis_tready <= 1'b1;
                RX_PATTERN: m_axis_tready <= rx_pattern[0];
                default:    m_axis_tready <= ($urandom_range(7, 0) == 0);
            endcase
        end
    end

    initial begin
        mismatch_count = 0;
        model_count    = 0;
        model_pos      = 0;
        model_sum      = '0;

        // Empty table, unused opcode, duplicates and key extremes.
        add_cmd(OP_QUERY, 31'd7);
        add_cmd(OP_NOP,   31'h7FFF_FFFF);
        add_cmd(OP_LOAD,  31'd0);
        add_cmd(OP_LOAD,  31'd5);
        add_cmd(OP_LOAD,  31'd5);
        add_cmd(OP_LOAD,  31'h7FFF_FFFF);
        add_cmd(OP_QUERY, 31'h7FFF_FFFF);
        add_cmd(OP_QUERY, 31'd5);
        add_cmd(OP_QUERY, 31'd0);
        add_cmd(OP_QUERY, 31'd3);
        add_cmd(OP_QUERY, 31'h7FFF_FFFE);
        add_cmd(OP_NOP,   31'd0);
        add_cmd(OP_CLEAR, 31'h5555_5555);
        add_cmd(OP_QUERY, 31'd5);
        // Out-of-order loads, then a key above every entry.
        add_cmd(OP_LOAD,  31'd100);
        add_cmd(OP_LOAD,  31'd50);
        add_cmd(OP_LOAD,  31'd200);
        add_cmd(OP_QUERY, 31'd50);
        add_cmd(OP_QUERY, 31'd200);
        add_cmd(OP_QUERY, 31'd100);
        add_cmd(OP_QUERY, 31'd300);
        add_cmd(OP_LOAD,  31'h2AAA_AAAA);
        add_cmd(OP_LOAD,  31'h5555_5555);
        add_cmd(OP_QUERY, 31'h2AAA_AAAA);

        // Fill the table completely, overrun it, and search at full depth.
        add_cmd(OP_CLEAR, KEY_W'($urandom));
        add_ascending_loads(TABLE_DEPTH, 32'd1 << 21);
        repeat (3) add_cmd(OP_LOAD, KEY_W'($urandom));
        add_queries(60);

        while (pending_cmds.size() < STIM_ITEMS) begin
            if ($urandom_range(3, 0) != 0) begin
                add_cmd(OP_CLEAR, KEY_W'($urandom));
            end
            case ($urandom_range(2, 0))
                0:       add_ascending_loads($urandom_range(40, 0), 3);
                1:       add_ascending_loads($urandom_range(40, 0), 32'd1 << 12);
                default: add_ascending_loads($urandom_range(40, 0), 32'd1 << 24);
            endcase
            case ($urandom_range(9, 0))
                0: repeat ($urandom_range(5, 1)) add_cmd(OP_LOAD, KEY_W'($urandom));
                1: repeat ($urandom_range(8, 3)) add_cmd(OP_W'($urandom), KEY_W'($urandom));
                default: begin
                end
            endcase
            add_queries($urandom_range(30, 5));
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || s_axis_tvalid || predicted_replies.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
